// ===== src/icp_pkg.sv =====
// shared constants, types and fixed-point helpers for the iteration color palette
package icp_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int LIMIT_W        = 16;
  localparam int ROT_W          = 3;
  localparam int PIX_W          = 8;
  localparam int FRAC_BITS      = 24;
  localparam int Q_W            = FRAC_BITS + 1;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RST    = LIMIT_W'(64);
  localparam logic [ROT_W-1:0]   ROTATION_RST = '0;

  localparam logic [11:0] K_OUTER = 12'(9 * 255);
  localparam logic [11:0] K_MID   = 12'(15 * 255);

  localparam logic [Q_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  // input register + divider stages + polynomial stages, then two output slots
  localparam int PIPE_DEPTH = 1 + FRAC_BITS + 4;
  localparam int CAPACITY   = PIPE_DEPTH + 2;
  localparam int OCC_W      = $clog2(CAPACITY + 1);

  typedef enum logic [APB_ADDR_W-1:0] {
    REG_LIMIT    = 3'd0,
    REG_ROTATION = 3'd4
  } reg_addr_t;

  typedef enum logic [ROT_W-1:0] {
    ROT_ABC   = 3'd0,
    ROT_CAB   = 3'd1,
    ROT_BCA   = 3'd2,
    ROT_CBA   = 3'd3,
    ROT_ACB   = 3'd4,
    ROT_BAC   = 3'd5,
    ROT_CBA_2 = 3'd6,
    ROT_ACB_2 = 3'd7
  } rot_t;

  typedef struct packed {
    logic           valid;
    logic [Q_W-1:0] t;
  } div_out_t;

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] pa;
    logic [PIX_W-1:0] pb;
    logic [PIX_W-1:0] pc;
  } poly_out_t;

  function automatic logic [Q_W-1:0] qmul(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b);
    logic [2*Q_W-1:0] p;
    p = a * b;
    return p[FRAC_BITS+Q_W-1:FRAC_BITS];
  endfunction

  function automatic logic [PIX_W-1:0] scale8(input logic [Q_W-1:0] q, input logic [11:0] k);
    logic [Q_W+11:0]           p;
    logic [Q_W+11-FRAC_BITS:0] v;
    p = q * k;
    v = p[Q_W+11:FRAC_BITS];
    return (v > 13'd255) ? 8'd255 : v[PIX_W-1:0];
  endfunction

endpackage

// ===== src/icp_div.sv =====
// pipelined restoring divider, one quotient bit per stage, gives t = count / limit in q24
module icp_div import icp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic               in_full,
  input  logic [LIMIT_W-1:0] in_rem,
  input  logic [LIMIT_W-1:0] lim,
  output div_out_t           dout
);

  logic                 v_r    [FRAC_BITS];
  logic                 full_r [FRAC_BITS];
  logic [LIMIT_W-1:0]   rem_r  [FRAC_BITS];
  logic [FRAC_BITS-1:0] q_r    [FRAC_BITS];
  logic [LIMIT_W-1:0]   rem_nxt[FRAC_BITS];
  logic [FRAC_BITS-1:0] q_nxt  [FRAC_BITS];
  logic [LIMIT_W-1:0]   src_rem[FRAC_BITS];
  logic [FRAC_BITS-1:0] src_q  [FRAC_BITS];
  logic [LIMIT_W:0]     dbl    [FRAC_BITS];

  always_comb begin
    for (int k = 0; k < FRAC_BITS; k++) begin
      src_rem[k] = (k == 0) ? in_rem : rem_r[(k == 0) ? 0 : k - 1];
      src_q[k]   = (k == 0) ? '0 : q_r[(k == 0) ? 0 : k - 1];
      dbl[k]     = {src_rem[k], 1'b0};
      if (dbl[k] >= {1'b0, lim}) begin
        rem_nxt[k] = LIMIT_W'(dbl[k] - {1'b0, lim});
        q_nxt[k]   = {src_q[k][FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_nxt[k] = dbl[k][LIMIT_W-1:0];
        q_nxt[k]   = {src_q[k][FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < FRAC_BITS; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < FRAC_BITS; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      full_r[0] <= in_full;
      for (int k = 1; k < FRAC_BITS; k++) full_r[k] <= full_r[k-1];
      for (int k = 0; k < FRAC_BITS; k++) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
      end
    end
  end

  assign dout.valid = v_r[FRAC_BITS-1];
  assign dout.t     = full_r[FRAC_BITS-1] ? ONE_Q : {1'b0, q_r[FRAC_BITS-1]};

endmodule

// ===== src/icp_poly.sv =====
// pipelined evaluation of the three bernstein terms, one multiply level per stage
module icp_poly import icp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  div_out_t  din,
  output poly_out_t dout
);

  logic [3:0] v_r;

  // stage 1: powers of two
  logic [Q_W-1:0] s1_t_r, s1_u_r, s1_t2_r, s1_u2_r;
  // stage 2: powers of three and middle product
  logic [Q_W-1:0] s2_t_r, s2_u_r, s2_t3_r, s2_u3_r, s2_qb_r;
  // stage 3: outer products
  logic [Q_W-1:0] s3_qa_r, s3_qb_r, s3_qc_r;
  // stage 4: scaled intensities
  logic [PIX_W-1:0] s4_pa_r, s4_pb_r, s4_pc_r;

  logic [Q_W-1:0] u_in;

  assign u_in = ONE_Q - din.t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], din.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_t_r  <= din.t;
      s1_u_r  <= u_in;
      s1_t2_r <= qmul(din.t, din.t);
      s1_u2_r <= qmul(u_in, u_in);

      s2_t_r  <= s1_t_r;
      s2_u_r  <= s1_u_r;
      s2_t3_r <= qmul(s1_t2_r, s1_t_r);
      s2_u3_r <= qmul(s1_u2_r, s1_u_r);
      s2_qb_r <= qmul(s1_u2_r, s1_t2_r);

      s3_qa_r <= qmul(s2_u_r, s2_t3_r);
      s3_qc_r <= qmul(s2_u3_r, s2_t_r);
      s3_qb_r <= s2_qb_r;

      s4_pa_r <= scale8(s3_qa_r, K_OUTER);
      s4_pb_r <= scale8(s3_qb_r, K_MID);
      s4_pc_r <= scale8(s3_qc_r, K_OUTER);
    end
  end

  assign dout.valid = v_r[3];
  assign dout.pa    = s4_pa_r;
  assign dout.pb    = s4_pb_r;
  assign dout.pc    = s4_pc_r;

endmodule

// ===== src/iteration_color_palette_unit.sv =====
// top level of the iteration color palette: config registers, pipeline and output buffer
//
// channel   direction  handshake             payload
// in_       input      in_valid / in_ready   in_iteration_count [COUNT_BITS]
// out_      output     out_valid / out_ready out_red, out_green, out_blue [8]
// apb       input      psel/penable/pwrite   paddr [3], pwdata / prdata [32]
//
// one transfer in per cycle while in_ready is high
// the pipeline is the input register, the 24 single-bit divider stages and four multiply stages
// rst_n is synchronous and clears all valid bits and the config registers
// a two-slot output buffer keeps taking transfers while a result waits; when both
// slots are full the pipeline freezes and in_ready drops, nothing is lost or repeated
module iteration_color_palette_unit import icp_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COUNT_BITS-1:0] in_iteration_count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      out_red,
  output logic [PIX_W-1:0]      out_green,
  output logic [PIX_W-1:0]      out_blue,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

  logic [LIMIT_W-1:0] limit_r;
  logic [ROT_W-1:0]   rotation_r;
  logic [LIMIT_W-1:0] lim_eff;
  logic               cfg_wr;

  logic               en;
  logic               s0_v_r;
  logic               s0_full_r;
  logic [LIMIT_W-1:0] s0_rem_r;
  logic [CMP_W-1:0]   cnt_ext;
  logic [CMP_W-1:0]   lim_ext;
  logic               in_xfer;

  div_out_t  div_out;
  poly_out_t poly_out;

  logic [PIX_W-1:0] mux_red, mux_green, mux_blue;

  logic             out_v_r, out_v_nxt;
  logic [PIX_W-1:0] out_red_r, out_green_r, out_blue_r;
  logic [PIX_W-1:0] out_red_nxt, out_green_nxt, out_blue_nxt;
  logic             skid_v_r, skid_v_nxt;
  logic [PIX_W-1:0] skid_red_r, skid_green_r, skid_blue_r;
  logic [PIX_W-1:0] skid_red_nxt, skid_green_nxt, skid_blue_nxt;
  logic             push, pop;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= LIMIT_RST;
      rotation_r <= ROTATION_RST;
    end else if (cfg_wr) begin
      unique case (paddr)
        REG_LIMIT:    limit_r    <= pwdata[LIMIT_W-1:0];
        REG_ROTATION: rotation_r <= pwdata[ROT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      REG_LIMIT:    prdata = APB_DATA_W'(limit_r);
      REG_ROTATION: prdata = APB_DATA_W'(rotation_r);
      default:      prdata = '0;
    endcase
  end

  assign lim_eff = (limit_r == '0) ? LIMIT_W'(1) : limit_r;

  // input register: saturate the count against the limit
  assign en       = !skid_v_r;
  assign in_ready = en;
  assign in_xfer  = in_valid && in_ready;
  assign cnt_ext  = CMP_W'(in_iteration_count);
  assign lim_ext  = CMP_W'(lim_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_full_r <= (cnt_ext >= lim_ext);
      s0_rem_r  <= (cnt_ext >= lim_ext) ? '0 : cnt_ext[LIMIT_W-1:0];
    end
  end

  icp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s0_v_r),
    .in_full  (s0_full_r),
    .in_rem   (s0_rem_r),
    .lim      (lim_eff),
    .dout     (div_out)
  );

  icp_poly u_poly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .din   (div_out),
    .dout  (poly_out)
  );

  // channel rotation
  always_comb begin
    unique case (rotation_r)
      ROT_ABC: begin
        mux_red = poly_out.pa; mux_green = poly_out.pb; mux_blue = poly_out.pc;
      end
      ROT_CAB: begin
        mux_red = poly_out.pc; mux_green = poly_out.pa; mux_blue = poly_out.pb;
      end
      ROT_BCA: begin
        mux_red = poly_out.pb; mux_green = poly_out.pc; mux_blue = poly_out.pa;
      end
      ROT_CBA, ROT_CBA_2: begin
        mux_red = poly_out.pc; mux_green = poly_out.pb; mux_blue = poly_out.pa;
      end
      ROT_ACB, ROT_ACB_2: begin
        mux_red = poly_out.pa; mux_green = poly_out.pc; mux_blue = poly_out.pb;
      end
      ROT_BAC: begin
        mux_red = poly_out.pb; mux_green = poly_out.pa; mux_blue = poly_out.pc;
      end
      default: begin
        mux_red = poly_out.pa; mux_green = poly_out.pb; mux_blue = poly_out.pc;
      end
    endcase
  end

  // output register plus skid slot
  assign push = en && poly_out.valid;
  assign pop  = out_v_r && out_ready;

  always_comb begin
    out_v_nxt      = out_v_r;
    out_red_nxt    = out_red_r;
    out_green_nxt  = out_green_r;
    out_blue_nxt   = out_blue_r;
    skid_v_nxt     = skid_v_r;
    skid_red_nxt   = skid_red_r;
    skid_green_nxt = skid_green_r;
    skid_blue_nxt  = skid_blue_r;
    if (skid_v_r) begin
      if (pop) begin
        out_red_nxt   = skid_red_r;
        out_green_nxt = skid_green_r;
        out_blue_nxt  = skid_blue_r;
        skid_v_nxt    = 1'b0;
      end
    end else if (push) begin
      if (!out_v_r || pop) begin
        out_v_nxt     = 1'b1;
        out_red_nxt   = mux_red;
        out_green_nxt = mux_green;
        out_blue_nxt  = mux_blue;
      end else begin
        skid_v_nxt     = 1'b1;
        skid_red_nxt   = mux_red;
        skid_green_nxt = mux_green;
        skid_blue_nxt  = mux_blue;
      end
    end else if (pop) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_red_r    <= out_red_nxt;
    out_green_r  <= out_green_nxt;
    out_blue_r   <= out_blue_nxt;
    skid_red_r   <= skid_red_nxt;
    skid_green_r <= skid_green_nxt;
    skid_blue_r  <= skid_blue_nxt;
  end

  assign out_valid = out_v_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

endmodule

// ===== src/icp_checker.sv =====
// port-level checker for the iteration color palette and its bind
module icp_checker import icp_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [PIX_W-1:0]      out_red,
  input logic [PIX_W-1:0]      out_green,
  input logic [PIX_W-1:0]      out_blue,
  input logic                  pready
);

  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_comb begin
    occ_nxt = occ_r;
    if (in_xfer && !out_xfer) occ_nxt = occ_r + OCC_W'(1);
    if (!in_xfer && out_xfer) occ_nxt = occ_r - OCC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
                                && $stable(out_blue))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> occ_r != '0)
    else $error("result with no transfer outstanding");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(CAPACITY) && (occ_r != OCC_W'(CAPACITY) || !in_ready || out_ready))
    else $error("more transfers in flight than pipeline slots");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind iteration_color_palette_unit icp_checker #(.COUNT_BITS(COUNT_BITS)) u_icp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue),
  .pready    (pready)
);
